@@ design/pot_pkg.sv @@
`default_nettype none

package pot_pkg;

	// Fixed field widths
	localparam int THR_W   = 15;
	localparam int STEP_W  = 12;
	localparam int WGT_W   = 24;
	localparam int POW_W   = 32;
	localparam int GAP_W   = POW_W + 1;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// Serial accumulator: one weight bit per cycle
	localparam int ACC_HI_W = 36;
	localparam int QUOT_W   = ACC_HI_W + WGT_W - 16;

	// 0.4 in Q0.16, fed through the accumulator like a weight
	localparam logic [WGT_W-1:0] STEP_DECAY_Q16 = 24'd26214;

	localparam logic [31:0] THROTTLE_FIRST   = 32'd7680;
	localparam logic [31:0] THROTTLE_SPACING = 32'd5120;
	localparam logic [31:0] THROTTLE_HUNDRED = 32'd25600;
	localparam logic signed [STEP_W-1:0] STEP_RESET = 12'sd1280;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_THROTTLE_UPPER  = 3'd0;
	localparam logic [2:0] REG_THROTTLE_LOWER  = 3'd1;
	localparam logic [2:0] REG_STEP_UPPER      = 3'd2;
	localparam logic [2:0] REG_STEP_LOWER      = 3'd3;
	localparam logic [2:0] REG_WEIGHT_PERSONAL = 3'd4;
	localparam logic [2:0] REG_WEIGHT_GLOBAL   = 3'd5;

	// Register reset values
	localparam logic [THR_W-1:0] THROTTLE_UPPER_RST = 15'd25600;
	localparam logic [THR_W-1:0] THROTTLE_LOWER_RST = 15'd0;
	localparam logic signed [STEP_W-1:0] STEP_UPPER_RST = 12'sd1280;
	localparam logic signed [STEP_W-1:0] STEP_LOWER_RST = -12'sd1280;
	localparam logic [WGT_W-1:0] WEIGHT_RST = 24'd2507271;

	typedef struct packed {
		logic [THR_W-1:0]         throttle_upper;
		logic [THR_W-1:0]         throttle_lower;
		logic signed [STEP_W-1:0] step_upper;
		logic signed [STEP_W-1:0] step_lower;
		logic [WGT_W-1:0]         weight_personal;
		logic [WGT_W-1:0]         weight_global;
	} cfg_t;

	// Starting throttle of a particle: 30 + 20*i percent, capped at 100
	function automatic logic [THR_W-1:0] throttle_reset(input int unsigned i);
		logic [31:0] t;
		t = THROTTLE_FIRST + THROTTLE_SPACING * i;
		if (t > THROTTLE_HUNDRED) begin
			t = THROTTLE_HUNDRED;
		end
		return t[THR_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ design/pot_in_if.sv @@
`default_nettype none

interface pot_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             particle_index;
	logic [SAMPLE_BITS-1:0] current_sample;
	logic [SAMPLE_BITS-1:0] voltage_sample;

	modport source (
		output valid, particle_index, current_sample, voltage_sample,
		input  ready
	);
	modport sink (
		input  valid, particle_index, current_sample, voltage_sample,
		output ready
	);
endinterface

`default_nettype wire

@@ design/pot_out_if.sv @@
`default_nettype none

interface pot_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] next_throttle;
	logic [14:0] best_throttle;
	logic [31:0] best_power;

	modport source (
		output valid, next_throttle, best_throttle, best_power,
		input  ready
	);
	modport sink (
		input  valid, next_throttle, best_throttle, best_power,
		output ready
	);
endinterface

`default_nettype wire

@@ design/pso_perturb_observe_tracker_core.sv @@
// Perturb-and-observe throttle tracker for a small particle swarm.
// meas (sink): one item per measurement, naming a particle and carrying the
//   current and voltage sampled at that particle's throttle.
// res (source): one item per measurement with the particle's new throttle
//   and the global best throttle and power after the update.
// APB port: six limit and weight registers at byte addresses 0..20; the user
//   must write them only while the block is idle; the block does not enforce
//   it. Reads return the register values.
// Sequence after accept: the bit-serial power multiplier (one sample bit per
//   cycle), the gap state in which the accumulator latches the gaps, the serial
//   step accumulator (one weight bit per cycle over 24 bits), the move, and
//   the load of the output register. An out-of-range particle index goes
//   straight to the output register and changes no particle state.
// Throughput: one item at a time; the next item can be accepted in the cycle
//   after the previous one is loaded into the output register.
// Stall: the result waits in the output register while res.ready is low; a
//   new item may be accepted meanwhile and then waits for the register.
// Reset: arst_n clears all particle state to the starting throttles, the
//   default step and zero powers, and loads the register defaults.
`default_nettype none

module pso_perturb_observe_tracker_core import pot_pkg::*; #(
	parameter int PARTICLES   = 3,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	pot_in_if.sink                 meas,
	pot_out_if.source              res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	localparam int IW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_GAP  = 6'b000100,
		ST_MAC  = 6'b001000,
		ST_MOVE = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	// Particle state
	logic [THR_W-1:0]         thr_q   [PARTICLES];
	logic [THR_W-1:0]         pthr_q  [PARTICLES];
	logic signed [STEP_W-1:0] step_q  [PARTICLES];
	logic [POW_W-1:0]         ppow_q  [PARTICLES];
	logic [POW_W-1:0]         pbest_q [PARTICLES];
	logic [POW_W-1:0]         gbest_q;
	logic [THR_W-1:0]         gthr_q;

	// Current item
	logic [IW-1:0]            sel_q;
	logic [POW_W-1:0]         power_q;
	logic signed [STEP_W-1:0] nstep_q;
	logic [THR_W-1:0]         next_q;

	// Output register
	logic                     ovalid_q;
	logic [THR_W-1:0]         onext_q;
	logic [THR_W-1:0]         othr_q;
	logic [POW_W-1:0]         opow_q;

	logic                     accept;
	logic [4:0]               idx_ext;
	logic                     in_range;
	logic                     mul_done;
	logic [POW_W-1:0]         mul_power;
	logic                     mac_start;
	logic                     mac_done;
	logic signed [STEP_W-1:0] mac_step;
	logic signed [GAP_W-1:0]  gap_p;
	logic signed [GAP_W-1:0]  gap_g;
	logic                     rose;
	logic                     up;
	logic signed [THR_W+1:0]  thr_s;
	logic signed [THR_W+1:0]  step_s;
	logic signed [THR_W+1:0]  moved;
	logic signed [THR_W+1:0]  tu_s;
	logic signed [THR_W+1:0]  tl_s;
	logic signed [THR_W+1:0]  clamp1;
	logic [THR_W-1:0]         next_thr;
	logic                     load_out;

	pot_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input handshake and index check
	assign meas.ready = (state_q == ST_IDLE);
	assign accept     = meas.valid & meas.ready;
	assign idx_ext    = {3'd0, meas.particle_index};
	assign in_range   = (idx_ext < 5'(PARTICLES));

	pot_mul #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept & in_range),
		.mcand  (meas.current_sample),
		.mplier (meas.voltage_sample),
		.done   (mul_done),
		.power  (mul_power)
	);

	// Gaps to personal and global best
	assign gap_p     = $signed({1'b0, pbest_q[sel_q]}) - $signed({1'b0, power_q});
	assign gap_g     = $signed({1'b0, gbest_q}) - $signed({1'b0, power_q});
	assign mac_start = (state_q == ST_GAP);

	pot_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mac_start),
		.gap_personal (gap_p),
		.gap_global   (gap_g),
		.step_old     (step_q[sel_q]),
		.cfg          (cfg),
		.done         (mac_done),
		.step_new     (mac_step)
	);

	// Perturb direction and throttle clamp
	assign rose   = power_q > ppow_q[sel_q];
	assign up     = thr_q[sel_q] > pthr_q[sel_q];
	assign thr_s  = {2'b00, thr_q[sel_q]};
	assign step_s = (THR_W + 2)'(nstep_q);
	assign moved  = (rose == up) ? (thr_s + step_s) : (thr_s - step_s);
	assign tu_s   = {2'b00, cfg.throttle_upper};
	assign tl_s   = {2'b00, cfg.throttle_lower};
	assign clamp1 = (moved > tu_s) ? tu_s : moved;
	assign next_thr = (clamp1 < tl_s) ? cfg.throttle_lower : clamp1[THR_W-1:0];

	assign load_out = (state_q == ST_DONE) & (~ovalid_q | res.ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= in_range ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_GAP;
					end
				end
				ST_GAP: state_q <= ST_MAC;
				ST_MAC: begin
					if (mac_done) begin
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Per-item working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q  <= idx_ext[IW-1:0];
			next_q <= '0;
		end
		if (state_q == ST_MUL && mul_done) begin
			power_q <= mul_power;
		end
		if (state_q == ST_MAC && mac_done) begin
			nstep_q <= mac_step;
		end
		if (state_q == ST_MOVE) begin
			next_q <= next_thr;
		end
	end

	// Particle and best state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PARTICLES; k++) begin
				thr_q[k]   <= throttle_reset(k);
				pthr_q[k]  <= throttle_reset(k);
				step_q[k]  <= STEP_RESET;
				ppow_q[k]  <= '0;
				pbest_q[k] <= '0;
			end
			gbest_q <= '0;
			gthr_q  <= THROTTLE_FIRST[THR_W-1:0];
		end else if (state_q == ST_MOVE) begin
			step_q[sel_q] <= nstep_q;
			ppow_q[sel_q] <= power_q;
			pthr_q[sel_q] <= thr_q[sel_q];
			thr_q[sel_q]  <= next_thr;
			if (power_q > pbest_q[sel_q]) begin
				pbest_q[sel_q] <= power_q;
			end
			if (power_q > gbest_q) begin
				gbest_q <= power_q;
				gthr_q  <= next_thr;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load_out) begin
			ovalid_q <= 1'b1;
		end else if (res.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			onext_q <= next_q;
			othr_q  <= gthr_q;
			opow_q  <= gbest_q;
		end
	end

	assign res.valid         = ovalid_q;
	assign res.next_throttle = onext_q;
	assign res.best_throttle = othr_q;
	assign res.best_power    = opow_q;

endmodule

`default_nettype wire

@@ design/pot_cfg.sv @@
`default_nettype none

module pot_cfg import pot_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.throttle_upper  <= THROTTLE_UPPER_RST;
			cfg_q.throttle_lower  <= THROTTLE_LOWER_RST;
			cfg_q.step_upper      <= STEP_UPPER_RST;
			cfg_q.step_lower      <= STEP_LOWER_RST;
			cfg_q.weight_personal <= WEIGHT_RST;
			cfg_q.weight_global   <= WEIGHT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_THROTTLE_UPPER:  cfg_q.throttle_upper  <= pwdata[THR_W-1:0];
				REG_THROTTLE_LOWER:  cfg_q.throttle_lower  <= pwdata[THR_W-1:0];
				REG_STEP_UPPER:      cfg_q.step_upper      <= pwdata[STEP_W-1:0];
				REG_STEP_LOWER:      cfg_q.step_lower      <= pwdata[STEP_W-1:0];
				REG_WEIGHT_PERSONAL: cfg_q.weight_personal <= pwdata[WGT_W-1:0];
				REG_WEIGHT_GLOBAL:   cfg_q.weight_global   <= pwdata[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux; step limits read back sign-extended
	always_comb begin
		case (reg_idx)
			REG_THROTTLE_UPPER:  prdata = {17'd0, cfg_q.throttle_upper};
			REG_THROTTLE_LOWER:  prdata = {17'd0, cfg_q.throttle_lower};
			REG_STEP_UPPER:      prdata = {{20{cfg_q.step_upper[STEP_W-1]}}, cfg_q.step_upper};
			REG_STEP_LOWER:      prdata = {{20{cfg_q.step_lower[STEP_W-1]}}, cfg_q.step_lower};
			REG_WEIGHT_PERSONAL: prdata = {8'd0, cfg_q.weight_personal};
			REG_WEIGHT_GLOBAL:   prdata = {8'd0, cfg_q.weight_global};
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ design/pot_mul.sv @@
`default_nettype none

// Bit-serial shift-add multiplier: one bit of the voltage per cycle.
module pot_mul import pot_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SAMPLE_BITS-1:0] mcand,
	input  wire logic [SAMPLE_BITS-1:0] mplier,
	output logic                        done,
	output logic [POW_W-1:0]            power
);

	localparam int CW = $clog2(SAMPLE_BITS);
	localparam int PW = 2 * SAMPLE_BITS;

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic [SAMPLE_BITS-1:0] mcand_q;
	logic [SAMPLE_BITS:0]   hi_q;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [SAMPLE_BITS:0]   sum;
	logic [PW-1:0]          prod;
	logic [PW+POW_W-1:0]    prod_ext;

	// One partial product per cycle
	assign sum = hi_q + (lo_q[0] ? {1'b0, mcand_q} : '0);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SAMPLE_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath shift register
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			hi_q    <= '0;
			lo_q    <= mplier;
		end else if (busy_q) begin
			hi_q <= {1'b0, sum[SAMPLE_BITS:1]};
			lo_q <= {sum[0], lo_q[SAMPLE_BITS-1:1]};
		end
	end

	// Saturate to 32 bits
	assign prod     = {hi_q[SAMPLE_BITS-1:0], lo_q};
	assign prod_ext = {{POW_W{1'b0}}, prod};
	assign power    = (|prod_ext[PW+POW_W-1:POW_W]) ? '1 : prod_ext[POW_W-1:0];
	assign done     = done_q;

endmodule

`default_nettype wire

@@ design/pot_mac.sv @@
`default_nettype none

// Serial step accumulator. Each cycle takes one bit of both weights and of the
// decay constant and adds the selected gaps and old step into the high half.
// Once the last weight bit is taken, {hi, lo} holds the exact step sum.
module pot_mac import pot_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [GAP_W-1:0]  gap_personal,
	input  wire logic signed [GAP_W-1:0]  gap_global,
	input  wire logic signed [STEP_W-1:0] step_old,
	input  wire cfg_t                     cfg,
	output logic                          done,
	output logic signed [STEP_W-1:0]      step_new
);

	logic                       busy_q;
	logic                       done_q;
	logic [4:0]                 cnt_q;
	logic [WGT_W-1:0]           wp_q;
	logic [WGT_W-1:0]           wg_q;
	logic [WGT_W-1:0]           dc_q;
	logic signed [GAP_W-1:0]    gp_q;
	logic signed [GAP_W-1:0]    gg_q;
	logic signed [STEP_W-1:0]   st_q;
	logic signed [ACC_HI_W-1:0] hi_q;
	logic [WGT_W-1:0]           lo_q;
	logic signed [ACC_HI_W-1:0] add_p;
	logic signed [ACC_HI_W-1:0] add_g;
	logic signed [ACC_HI_W-1:0] add_s;
	logic signed [ACC_HI_W-1:0] sum;
	logic signed [QUOT_W-1:0]   quot;
	logic signed [QUOT_W-1:0]   su_x;
	logic signed [QUOT_W-1:0]   sl_x;
	logic signed [QUOT_W-1:0]   c1;

	// Selected terms for this weight bit
	assign add_p = wp_q[0] ? ACC_HI_W'(gp_q) : '0;
	assign add_g = wg_q[0] ? ACC_HI_W'(gg_q) : '0;
	assign add_s = dc_q[0] ? ACC_HI_W'(st_q) : '0;
	assign sum   = hi_q + add_p + add_g + add_s;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(WGT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Weight shift registers and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			wp_q <= cfg.weight_personal;
			wg_q <= cfg.weight_global;
			dc_q <= STEP_DECAY_Q16;
			gp_q <= gap_personal;
			gg_q <= gap_global;
			st_q <= step_old;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			wp_q <= wp_q >> 1;
			wg_q <= wg_q >> 1;
			dc_q <= dc_q >> 1;
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[WGT_W-1:1]};
		end
	end

	// Floor divide by 65536, then clamp to upper and lower step limits
	assign quot = {hi_q, lo_q[WGT_W-1:16]};
	assign su_x = QUOT_W'(cfg.step_upper);
	assign sl_x = QUOT_W'(cfg.step_lower);
	assign c1   = (quot > su_x) ? su_x : quot;

	assign step_new = (c1 < sl_x) ? cfg.step_lower : c1[STEP_W-1:0];
	assign done     = done_q;

endmodule

`default_nettype wire
